### rtl/lru_keyed_object_cache_defines.svh
// Assertion helpers shared by the RTL.
`ifndef LRU_KEYED_OBJECT_CACHE_DEFINES_SVH
`define LRU_KEYED_OBJECT_CACHE_DEFINES_SVH

// Implication checked on every clock edge, ignored during reset.
`define LKOC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define LKOC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### rtl/lkoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lkoc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_STATS  = 3'd4;
    localparam logic [2:0] ACT_INFO   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] key;
        logic [31:0] handle;
        logic [47:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_out;
        logic        dropped;
        logic [31:0] dropped_handle;
        logic [6:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
        logic [31:0] uses;
        logic [47:0] last_used;
        logic [47:0] loaded_at;
        logic        last;
    } t_out;

    // Word passed down the cell chain during a scan.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] fidx;
        logic [31:0]      f_handle;
        logic [31:0]      f_uses;
        logic [47:0]      f_last;
        logic [47:0]      f_load;
        logic             has_empty;
        logic [IDX_W-1:0] eidx;
        logic             has_old;
        logic [IDX_W-1:0] oidx;
        logic [47:0]      o_time;
        logic [31:0]      o_handle;
        logic [CNT_W-1:0] count;
    } t_scan;

    // Update broadcast to all cells.
    typedef struct packed {
        logic             wr;
        logic             touch;
        logic             inval;
        logic [IDX_W-1:0] idx;
        logic [63:0]      key;
        logic [31:0]      handle;
        logic [47:0]      now_ms;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/lkoc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lkoc_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [lkoc_pkg::IDX_W-1:0] i_idx,
    input  wire logic [63:0]               i_key,
    input  wire lkoc_pkg::t_scan           i_scan,
    input  wire lkoc_pkg::t_cmd            i_cmd,
    output lkoc_pkg::t_scan                o_scan,
    output logic                           o_valid,
    output logic [31:0]                    o_handle
);

    logic        r_valid;
    logic [63:0] r_key;
    logic [31:0] r_handle;
    logic [47:0] r_last;
    logic [31:0] r_uses;
    logic [47:0] r_load;
    lkoc_pkg::t_scan r_scan, n_scan;
    logic        sel;

    assign sel = (i_cmd.idx == i_idx);

    always_comb begin
        n_scan = i_scan;
        if (r_valid && r_key == i_key && !i_scan.found) begin
            n_scan.found    = 1'b1;
            n_scan.fidx     = i_idx;
            n_scan.f_handle = r_handle;
            n_scan.f_uses   = r_uses;
            n_scan.f_last   = r_last;
            n_scan.f_load   = r_load;
        end
        if (!r_valid && !i_scan.has_empty) begin
            n_scan.has_empty = 1'b1;
            n_scan.eidx      = i_idx;
        end
        if (r_valid) begin
            n_scan.count = i_scan.count + lkoc_pkg::CNT_W'(1);
            if (!i_scan.has_old || r_last < i_scan.o_time) begin
                n_scan.has_old  = 1'b1;
                n_scan.oidx     = i_idx;
                n_scan.o_time   = r_last;
                n_scan.o_handle = r_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && i_cmd.wr) begin
            r_valid <= 1'b1;
        end else if (sel && i_cmd.inval) begin
            r_valid <= 1'b0;
        end
        if (sel && i_cmd.wr) begin
            r_key    <= i_cmd.key;
            r_handle <= i_cmd.handle;
            r_last   <= i_cmd.now_ms;
            r_load   <= i_cmd.now_ms;
            r_uses   <= 32'd1;
        end else if (sel && i_cmd.touch) begin
            r_last <= i_cmd.now_ms;
            r_uses <= r_uses + 32'd1;
        end
    end

    assign o_scan   = r_scan;
    assign o_valid  = r_valid;
    assign o_handle = r_handle;

endmodule
`default_nettype wire

### rtl/lru_keyed_object_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | handshake          | word
// command   | in        | i_start, o_busy    | i_cmd_word (t_in)
// result    | out       | o_valid (strobe)   | o_res (t_out)
//
// Busy holds after a word is taken while the key walks the cell chain (one register
// per cell), then while the result is registered and the selected cell is updated.
// The result strobes in the next cycle with busy low; a new word is taken only while busy is low.
// Clear then visits slots one per cycle up to the highest valid one.
// Reset is synchronous, active low; it empties all slots and zeroes counters.
// Results are one-cycle strobes; the receiver cannot stall.
module lru_keyed_object_cache (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire lkoc_pkg::t_in i_cmd_word,
    output logic               o_busy,
    output logic               o_valid,
    output lkoc_pkg::t_out     o_res
);
    `include "lru_keyed_object_cache_defines.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    localparam int E = lkoc_pkg::ENTRIES;

    logic [1:0]                 r_state, n_state;
    logic [lkoc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    lkoc_pkg::t_in              r_in;
    lkoc_pkg::t_out             r_out, n_out;
    logic                       r_stb, n_stb;
    logic [31:0]                r_hits, n_hits, r_miss, n_miss, r_evict, n_evict;
    lkoc_pkg::t_cmd             w_cmd;
    lkoc_pkg::t_scan            w_chain [E+1];
    lkoc_pkg::t_scan            w_res;
    logic [E-1:0]               w_valid;
    logic [31:0]                w_handle [E];
    logic [lkoc_pkg::IDX_W-1:0] w_cidx;
    logic [E-1:0]               w_above;

    assign w_chain[0] = '0;
    assign w_res      = w_chain[E];
    assign w_cidx     = r_cnt[lkoc_pkg::IDX_W-1:0];
    assign w_above    = (w_valid >> w_cidx) >> 1;

    for (genvar g = 0; g < E; g++) begin : g_cell
        lkoc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (lkoc_pkg::IDX_W'(g)),
            .i_key    (r_in.key),
            .i_scan   (w_chain[g]),
            .i_cmd    (w_cmd),
            .o_scan   (w_chain[g+1]),
            .o_valid  (w_valid[g]),
            .o_handle (w_handle[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_out   = '0;
        n_stb   = 1'b0;
        n_hits  = r_hits;
        n_miss  = r_miss;
        n_evict = r_evict;
        w_cmd   = '0;
        w_cmd.key    = r_in.key;
        w_cmd.handle = r_in.handle;
        w_cmd.now_ms = r_in.now_ms;
        n_out.last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (r_cnt != lkoc_pkg::CNT_W'(E)) begin
                    n_cnt = r_cnt + lkoc_pkg::CNT_W'(1);
                end else begin
                    n_state = S_IDLE;
                    n_stb   = 1'b1;
                    case (r_in.action)
                        lkoc_pkg::ACT_LOOKUP: begin
                            if (w_res.found) begin
                                w_cmd.touch      = 1'b1;
                                w_cmd.idx        = w_res.fidx;
                                n_hits           = r_hits + 32'd1;
                                n_out.handle_out = w_res.f_handle;
                            end else begin
                                n_miss       = r_miss + 32'd1;
                                n_out.status = lkoc_pkg::ST_MISS;
                            end
                        end
                        lkoc_pkg::ACT_ADD: begin
                            if (r_in.handle == 32'd0) begin
                                n_out.status = lkoc_pkg::ST_INVALID;
                            end else if (w_res.found) begin
                                n_out.status = lkoc_pkg::ST_DUP;
                            end else if (w_res.has_empty) begin
                                w_cmd.wr  = 1'b1;
                                w_cmd.idx = w_res.eidx;
                            end else begin
                                w_cmd.wr             = 1'b1;
                                w_cmd.idx            = w_res.oidx;
                                n_out.dropped        = 1'b1;
                                n_out.dropped_handle = w_res.o_handle;
                                n_evict              = r_evict + 32'd1;
                            end
                        end
                        lkoc_pkg::ACT_REMOVE: begin
                            if (w_res.found) begin
                                w_cmd.inval          = 1'b1;
                                w_cmd.idx            = w_res.fidx;
                                n_out.dropped        = 1'b1;
                                n_out.dropped_handle = w_res.f_handle;
                            end else begin
                                n_out.status = lkoc_pkg::ST_MISS;
                            end
                        end
                        lkoc_pkg::ACT_CLEAR: begin
                            if (w_res.count != '0) begin
                                n_stb   = 1'b0;
                                n_state = S_CLEAR;
                                n_cnt   = '0;
                            end
                        end
                        lkoc_pkg::ACT_STATS: begin
                            n_out.entry_count = 7'(w_res.count);
                            n_out.hit_total   = r_hits;
                            n_out.miss_total  = r_miss;
                            n_out.evict_total = r_evict;
                        end
                        lkoc_pkg::ACT_INFO: begin
                            if (w_res.found) begin
                                n_out.uses      = w_res.f_uses;
                                n_out.last_used = w_res.f_last;
                                n_out.loaded_at = w_res.f_load;
                            end else begin
                                n_out.status = lkoc_pkg::ST_MISS;
                            end
                        end
                        default: n_out.status = lkoc_pkg::ST_INVALID;
                    endcase
                end
            end
            S_CLEAR: begin
                n_cnt = r_cnt + lkoc_pkg::CNT_W'(1);
                if (w_valid[w_cidx]) begin
                    n_stb                = 1'b1;
                    w_cmd.inval          = 1'b1;
                    w_cmd.idx            = w_cidx;
                    n_out.dropped        = 1'b1;
                    n_out.dropped_handle = w_handle[w_cidx];
                    n_out.last           = (w_above == '0);
                    if (w_above == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_stb   <= 1'b0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_evict <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stb   <= n_stb;
            r_hits  <= n_hits;
            r_miss  <= n_miss;
            r_evict <= n_evict;
        end
        r_out <= n_out;
        if (r_state == S_IDLE && i_start) begin
            r_in <= i_cmd_word;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_stb;
    assign o_res   = r_out;

    `LKOC_ASSERT(a_start_busy, i_start && !o_busy |=> o_busy, "taken word did not raise busy")
    `LKOC_NEVER(a_dup_drop, o_valid && o_res.status == lkoc_pkg::ST_DUP && o_res.dropped, "dup drop")
    `LKOC_NEVER(a_drop_null, o_valid && o_res.dropped && o_res.dropped_handle == 32'd0, "null drop")

endmodule
`default_nettype wire

### bench/tb_lru_keyed_object_cache.sv
`timescale 1ns / 1ps
module tb_lru_keyed_object_cache;

    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RAND = 236;

    typedef struct {
        lkoc_pkg::t_in  word;
        bit             typed;
        lkoc_pkg::t_out res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    lkoc_pkg::t_in  i_cmd_word = '0;
    logic o_busy;
    logic o_valid;
    lkoc_pkg::t_out o_res;

    lru_keyed_object_cache u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_cmd_word(i_cmd_word), .o_busy(o_busy), .o_valid(o_valid), .o_res(o_res)
    );

    always #2 i_clk = ~i_clk;

    // cache shadow
    bit          c_valid [lkoc_pkg::ENTRIES];
    logic [63:0] c_key   [lkoc_pkg::ENTRIES];
    logic [31:0] c_handle[lkoc_pkg::ENTRIES];
    logic [47:0] c_lru   [lkoc_pkg::ENTRIES];
    logic [31:0] c_uses  [lkoc_pkg::ENTRIES];
    logic [47:0] c_load  [lkoc_pkg::ENTRIES];
    logic [31:0] n_hits, n_misses, n_evicts;

    lkoc_pkg::t_out pending_res[$];
    int   n_err = 0;
    int   idle_cycles = 0;
    logic [63:0] key_pool[10];
    logic [47:0] clock_ms;
    t_row rows[$];

    function automatic lkoc_pkg::t_out blank_res();
        lkoc_pkg::t_out r;
        r = '0;
        return r;
    endfunction

    task automatic cache_predict(input lkoc_pkg::t_in w, input bit push);
        lkoc_pkg::t_out r;
        int   slot;
        int   cnt;
        slot = -1;
        for (int i = 0; i < lkoc_pkg::ENTRIES; i++)
            if (slot < 0 && c_valid[i] && c_key[i] == w.key) slot = i;
        if (w.action == lkoc_pkg::ACT_CLEAR) begin
            cnt = 0;
            for (int i = 0; i < lkoc_pkg::ENTRIES; i++) begin
                if (c_valid[i]) begin
                    r = blank_res();
                    r.dropped = 1'b1;
                    r.dropped_handle = c_handle[i];
                    c_valid[i] = 1'b0;
                    if (push) pending_res.push_back(r);
                    cnt++;
                end
            end
            if (cnt == 0 && push) pending_res.push_back(blank_res());
            if (push) pending_res[pending_res.size() - 1].last = 1'b1;
            return;
        end
        r = blank_res();
        r.last = 1'b1;
        case (w.action)
            lkoc_pkg::ACT_LOOKUP: begin
                if (slot >= 0) begin
                    c_lru[slot] = w.now_ms;
                    c_uses[slot]++;
                    n_hits++;
                    r.handle_out = c_handle[slot];
                end else begin
                    n_misses++;
                    r.status = lkoc_pkg::ST_MISS;
                end
            end
            lkoc_pkg::ACT_ADD: begin
                if (w.handle == '0) r.status = lkoc_pkg::ST_INVALID;
                else if (slot >= 0) r.status = lkoc_pkg::ST_DUP;
                else begin
                    for (int i = 0; i < lkoc_pkg::ENTRIES; i++)
                        if (slot < 0 && !c_valid[i]) slot = i;
                    if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < lkoc_pkg::ENTRIES; i++)
                            if (c_lru[i] < c_lru[slot]) slot = i;
                        r.dropped = 1'b1;
                        r.dropped_handle = c_handle[slot];
                        n_evicts++;
                    end
                    c_valid[slot] = 1'b1;
                    c_key[slot] = w.key;
                    c_handle[slot] = w.handle;
                    c_lru[slot] = w.now_ms;
                    c_uses[slot] = 32'd1;
                    c_load[slot] = w.now_ms;
                end
            end
            lkoc_pkg::ACT_REMOVE: begin
                if (slot >= 0) begin
                    r.dropped = 1'b1;
                    r.dropped_handle = c_handle[slot];
                    c_valid[slot] = 1'b0;
                end else r.status = lkoc_pkg::ST_MISS;
            end
            lkoc_pkg::ACT_STATS: begin
                cnt = 0;
                for (int i = 0; i < lkoc_pkg::ENTRIES; i++) if (c_valid[i]) cnt++;
                r.entry_count = 7'(cnt);
                r.hit_total = n_hits;
                r.miss_total = n_misses;
                r.evict_total = n_evicts;
            end
            lkoc_pkg::ACT_INFO: begin
                if (slot >= 0) begin
                    r.uses = c_uses[slot];
                    r.last_used = c_lru[slot];
                    r.loaded_at = c_load[slot];
                end else r.status = lkoc_pkg::ST_MISS;
            end
            default: r.status = lkoc_pkg::ST_INVALID;
        endcase
        if (push) pending_res.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_res.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", o_res);
            end else begin
                if (o_res !== pending_res[0]) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp %h act %h", pending_res[0], o_res);
                end
                void'(pending_res.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // issue one word, hold start until taken
    task automatic send_word(input lkoc_pkg::t_in w, input bit typed,
                             input lkoc_pkg::t_out exp_r);
        i_start <= 1'b1;
        i_cmd_word <= w;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        if (typed) begin
            cache_predict(w, 1'b0);
            pending_res.push_back(exp_r);
        end else cache_predict(w, 1'b1);
    endtask

    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 3) == 0) begin
            g = $urandom_range(1, 20);
            i_start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic lkoc_pkg::t_in mk(input logic [2:0] a, input logic [63:0] k,
                                         input logic [31:0] h, input logic [47:0] t);
        lkoc_pkg::t_in w;
        w.action = a;
        w.key = k;
        w.handle = h;
        w.now_ms = t;
        return w;
    endfunction

    function automatic t_row row(input lkoc_pkg::t_in w, input bit typed,
                                 input lkoc_pkg::t_out r);
        t_row x;
        x.word = w;
        x.typed = typed;
        x.res = r;
        return x;
    endfunction

    function automatic lkoc_pkg::t_out st(input logic [1:0] s);
        lkoc_pkg::t_out r;
        r = blank_res();
        r.status = s;
        r.last = 1'b1;
        return r;
    endfunction

    initial begin
        lkoc_pkg::t_in  w;
        lkoc_pkg::t_out z;
        int   sel;
        for (int i = 0; i < lkoc_pkg::ENTRIES; i++) c_valid[i] = 1'b0;
        n_hits = '0;
        n_misses = '0;
        n_evicts = '0;
        z = blank_res();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(row(mk(lkoc_pkg::ACT_STATS, 64'd0, 32'd0, 48'd0), 1,
                           st(lkoc_pkg::ST_OK)));
        rows.push_back(row(mk(lkoc_pkg::ACT_CLEAR, 64'd0, 32'd0, 48'd0), 1,
                           st(lkoc_pkg::ST_OK)));
        rows.push_back(row(mk(lkoc_pkg::ACT_LOOKUP, 64'd5, 32'd0, 48'd1), 1,
                           st(lkoc_pkg::ST_MISS)));
        rows.push_back(row(mk(lkoc_pkg::ACT_REMOVE, 64'd5, 32'd0, 48'd1), 1,
                           st(lkoc_pkg::ST_MISS)));
        rows.push_back(row(mk(lkoc_pkg::ACT_INFO, 64'd5, 32'd0, 48'd1), 1,
                           st(lkoc_pkg::ST_MISS)));
        rows.push_back(row(mk(lkoc_pkg::ACT_ADD, 64'd5, 32'd0, 48'd1), 1,
                           st(lkoc_pkg::ST_INVALID)));
        rows.push_back(row(mk(ACT_RSVD6, '1, '1, '1), 1, st(lkoc_pkg::ST_INVALID)));
        rows.push_back(row(mk(ACT_RSVD7, '1, '1, '1), 1, st(lkoc_pkg::ST_INVALID)));
        rows.push_back(row(mk(lkoc_pkg::ACT_ADD, 64'd0, '1, 48'd2), 1,
                           st(lkoc_pkg::ST_OK)));
        rows.push_back(row(mk(lkoc_pkg::ACT_ADD, '1, 32'd1, '1), 1,
                           st(lkoc_pkg::ST_OK)));
        rows.push_back(row(mk(lkoc_pkg::ACT_ADD, 64'd0, 32'd7, 48'd3), 1,
                           st(lkoc_pkg::ST_DUP)));
        rows.push_back(row(mk(lkoc_pkg::ACT_LOOKUP, 64'd0, 32'd0, 48'd9), 0, z));
        rows.push_back(row(mk(lkoc_pkg::ACT_INFO, '1, 32'd0, 48'd9), 0, z));
        for (int i = 0; i < 7; i++)
            rows.push_back(row(mk(lkoc_pkg::ACT_ADD, 64'(i + 100), 32'(i + 50),
                                  48'(20 + i)), 0, z));
        rows.push_back(row(mk(lkoc_pkg::ACT_STATS, 64'd0, 32'd0, 48'd0), 0, z));
        rows.push_back(row(mk(lkoc_pkg::ACT_REMOVE, 64'd101, 32'd0, 48'd0), 0, z));
        rows.push_back(row(mk(lkoc_pkg::ACT_CLEAR, 64'd0, 32'd0, 48'd0), 0, z));
        rows.push_back(row(mk(lkoc_pkg::ACT_STATS, 64'd0, 32'd0, 48'd0), 0, z));

        foreach (rows[i]) begin
            send_word(rows[i].word, rows[i].typed, rows[i].res);
            maybe_gap();
        end

        i_start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        for (int i = 0; i < 10; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        clock_ms = 48'd100;
        for (int n = 0; n < N_RAND; n++) begin
            clock_ms = clock_ms + 48'($urandom_range(0, 40));
            sel = $urandom_range(0, 99);
            if (sel < 35) w.action = lkoc_pkg::ACT_LOOKUP;
            else if (sel < 65) w.action = lkoc_pkg::ACT_ADD;
            else if (sel < 78) w.action = lkoc_pkg::ACT_REMOVE;
            else if (sel < 84) w.action = lkoc_pkg::ACT_CLEAR;
            else if (sel < 90) w.action = lkoc_pkg::ACT_STATS;
            else if (sel < 97) w.action = lkoc_pkg::ACT_INFO;
            else w.action = 3'($urandom_range(6, 7));
            w.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, 9)];
            w.handle = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
            w.now_ms = ($urandom_range(0, 19) == 0) ? {16'($urandom), $urandom}
                                                    : clock_ms;
            send_word(w, 0, z);
            if (n % 64 < 48) maybe_gap();
        end

        i_start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_err == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

### lru_keyed_object_cache.f
+incdir+rtl
rtl/lkoc_pkg.sv
rtl/lkoc_cell.sv
rtl/lru_keyed_object_cache.sv
bench/tb_lru_keyed_object_cache.sv
